// ===== rtl/core/bbc_pkg.sv =====
// Shared types and constants for the bracket balance checker.
package bbc_pkg;

  // Operation kinds passed from the classifier to the stack engine
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Bracket codes held on the stack
  localparam logic [1:0] CODE_BRACE  = 2'd0;
  localparam logic [1:0] CODE_PAREN  = 2'd1;
  localparam logic [1:0] CODE_SQUARE = 2'd2;

  // Text bytes
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;

  localparam int unsigned CODE_W = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] code;
  } bbc_op_t;

endpackage

// ===== rtl/core/bbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bbc_front.sv =====
// Front end: accepts text bytes, classifies them and queues bracket operations.
module bbc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       symbol,
  input  logic             end_of_text,
  output logic             op_valid,
  output bbc_pkg::bbc_op_t op,
  input  logic             op_take
);

  bbc_pkg::bbc_op_t slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  bbc_pkg::bbc_op_t new_op;
  logic             keep;
  logic             accept;
  logic             write;
  logic             take;

  // Decode the byte; anything that is not a bracket has no effect and is dropped
  always_comb begin
    new_op.kind = bbc_pkg::OP_OPEN;
    new_op.code = bbc_pkg::CODE_BRACE;
    keep        = 1'b1;
    if (end_of_text) begin
      new_op.kind = bbc_pkg::OP_END;
    end else begin
      unique case (symbol)
        bbc_pkg::CH_LBRACE: begin
          new_op.kind = bbc_pkg::OP_OPEN;
          new_op.code = bbc_pkg::CODE_BRACE;
        end
        bbc_pkg::CH_LPAREN: begin
          new_op.kind = bbc_pkg::OP_OPEN;
          new_op.code = bbc_pkg::CODE_PAREN;
        end
        bbc_pkg::CH_LSQUARE: begin
          new_op.kind = bbc_pkg::OP_OPEN;
          new_op.code = bbc_pkg::CODE_SQUARE;
        end
        bbc_pkg::CH_RBRACE: begin
          new_op.kind = bbc_pkg::OP_CLOSE;
          new_op.code = bbc_pkg::CODE_BRACE;
        end
        bbc_pkg::CH_RPAREN: begin
          new_op.kind = bbc_pkg::OP_CLOSE;
          new_op.code = bbc_pkg::CODE_PAREN;
        end
        bbc_pkg::CH_RSQUARE: begin
          new_op.kind = bbc_pkg::OP_CLOSE;
          new_op.code = bbc_pkg::CODE_SQUARE;
        end
        default: begin
          keep = 1'b0;
        end
      endcase
    end
  end

  assign full     = (fill == 2'd2);
  assign op_valid = (fill != 2'd0);
  assign op       = slot[rd_ptr];
  assign accept   = push & ~full;
  assign write    = accept & keep;
  assign take     = op_take & op_valid;

  always_ff @(posedge clk) begin
    if (write) begin
      slot[wr_ptr] <= new_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (write) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({write, take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/bbc_back.sv =====
// Back end: runs the bracket stack, the sticky flags and the result register.
module bbc_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  input  bbc_pkg::bbc_op_t op,
  output logic             op_take,
  output logic             empty,
  input  logic             pop,
  output logic             balanced,
  output logic             overflowed
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [bbc_pkg::CODE_W-1:0] top;
  logic [bbc_pkg::CODE_W-1:0] top_next;
  logic                       fail_flag;
  logic                       fail_flag_next;
  logic                       overflow_flag;
  logic                       overflow_flag_next;
  logic                       out_valid;
  logic                       out_ready;
  logic                       consume;
  logic                       emit;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [bbc_pkg::CODE_W-1:0] below;

  assign out_ready = ~out_valid | pop;
  assign consume   = op_valid & ((op.kind != bbc_pkg::OP_END) | out_ready);
  assign op_take   = consume;
  assign emit      = consume & (op.kind == bbc_pkg::OP_END);
  assign waddr     = count[AW-1:0];
  // Keep the entry under the new top prefetched for the next pop
  assign raddr     = AW'(count_next - CW'(2));

  always_comb begin
    count_next         = count;
    top_next           = top;
    fail_flag_next     = fail_flag;
    overflow_flag_next = overflow_flag;
    we                 = 1'b0;
    if (consume) begin
      unique case (op.kind)
        bbc_pkg::OP_END: begin
          count_next         = '0;
          fail_flag_next     = 1'b0;
          overflow_flag_next = 1'b0;
        end
        bbc_pkg::OP_OPEN: begin
          if (!fail_flag) begin
            if (count >= FULL_COUNT) begin
              overflow_flag_next = 1'b1;
            end else begin
              we         = 1'b1;
              top_next   = op.code;
              count_next = count + CW'(1);
            end
          end
        end
        bbc_pkg::OP_CLOSE: begin
          if (!fail_flag) begin
            if (count != '0 && top == op.code) begin
              top_next   = below;
              count_next = count - CW'(1);
            end else begin
              fail_flag_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  bbc_ram #(
    .WIDTH (bbc_pkg::CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (op.code),
    .raddr (raddr),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    top <= top_next;
    if (emit) begin
      balanced   <= ~fail_flag & (count == '0);
      overflowed <= overflow_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      fail_flag     <= 1'b0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      count         <= count_next;
      fail_flag     <= fail_flag_next;
      overflow_flag <= overflow_flag_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = ~out_valid;

endmodule

// ===== rtl/core/bracket_balance_checker.sv =====
// Top level of the bracket balance checker: classifier, op queue and stack engine.
// Checks nesting of {} () [] over a byte stream at one byte per clock cycle while
// full is low. Push a byte each cycle with end_of_text low; non-bracket bytes are
// dropped at the front. A byte with end_of_text high closes the expression: one
// result (balanced, overflowed) is registered on the output queue when the stack
// engine retires its op; the checker starts fresh on the next byte. The front holds
// a two-entry op queue; the stack engine retires one op per cycle and stalls only
// on an end byte while the previous result is still waiting to be popped. The
// stack keeps its top in a register and prefetches the entry beneath it from a
// STACK_DEPTH x 2 RAM, so a push or pop every cycle needs no extra wait. Openers
// beyond STACK_DEPTH are dropped and reported through overflowed.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic       balanced,
  output logic       overflowed
);

  logic             op_valid;
  logic             op_take;
  bbc_pkg::bbc_op_t op;

  bbc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .op_valid    (op_valid),
    .op          (op),
    .op_take     (op_take)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op         (op),
    .op_take    (op_take),
    .empty      (empty),
    .pop        (pop),
    .balanced   (balanced),
    .overflowed (overflowed)
  );

  a_take_needs_op: assert property (@(posedge clk) disable iff (rst)
    op_take |-> op_valid)
    else $error("op taken from an empty queue");

  a_end_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (op_valid && op.kind == bbc_pkg::OP_END && !empty && !pop) |-> !op_take)
    else $error("end transaction retired over an unread result");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (op_take && op.kind == bbc_pkg::OP_END) |=> !empty)
    else $error("end transaction produced no result");

  a_full_has_ops: assert property (@(posedge clk) disable iff (rst)
    full |-> op_valid)
    else $error("queue full without a pending op");

endmodule
